// File: sv/bles_pkg.sv
// ----------------------------------------------------------------------------
// bles_pkg
// Shared types, constants and helpers of the beacon LED effect sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bles_pkg;

  localparam int unsigned MaxLeds    = 12;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned IdW        = 16;
  localparam int unsigned DurW       = 16;
  localparam int unsigned SeqW       = 8;
  localparam int unsigned CodeW      = 3;
  localparam int unsigned CountW     = 4;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned InDataW    = 32;
  localparam int unsigned OutDataW   = 16;

  localparam logic [TimeW-1:0]  BeatPeriod = 32'd5000;
  localparam logic [TimeW-1:0]  BeatFlash  = 32'd100;
  localparam logic [TimeW-1:0]  WaveStep   = 32'd70;
  localparam logic [SeqW-1:0]   SeqInit    = 8'hFF;
  localparam logic [CountW-1:0] LevelMask  = 4'hF;

  typedef enum logic [CodeW-1:0] {
    TrigShake     = 3'd0,
    TrigLumos     = 3'd1,
    TrigNox       = 3'd2,
    TrigIncendio  = 3'd3,
    TrigAguamenti = 3'd4,
    TrigWave      = 3'd5
  } trig_code_e;

  typedef enum logic [CfgAddrW-1:0] {
    RegDeviceId    = 3'd0,
    RegBroadcastId = 3'd1,
    RegLedCount    = 3'd2,
    RegShakeMs     = 3'd3,
    RegIncendioMs  = 3'd4,
    RegAguamentiMs = 3'd5,
    RegWaveMs      = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [IdW-1:0]    own_id;
    logic [IdW-1:0]    broadcast_id;
    logic [CountW-1:0] led_count;
    logic [DurW-1:0]   shake_ms;
    logic [DurW-1:0]   incendio_ms;
    logic [DurW-1:0]   aguamenti_ms;
    logic [DurW-1:0]   wave_ms;
  } cfg_t;

  typedef struct packed {
    logic             is_trig;
    logic [IdW-1:0]   dest_id;
    logic [CodeW-1:0] trigger_code;
    logic [SeqW-1:0]  seq;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic [MaxLeds-1:0] ext;
    logic               blue;
    logic               green;
    logic               red;
  } result_t;

  function automatic logic due(input logic [TimeW-1:0] now, input logic [TimeW-1:0] dl);
    logic [TimeW-1:0] diff;
    diff = now - dl;
    return ~diff[TimeW-1];
  endfunction

endpackage

`default_nettype wire

// File: sv/bles_cfg_regs.sv
// ----------------------------------------------------------------------------
// bles_cfg_regs
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bles_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bles_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [bles_pkg::CfgDataW-1:0] cfg_wdata_i,
  output bles_pkg::cfg_t                     cfg_o
);
  import bles_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        RegDeviceId:    cfg_d.own_id       = cfg_wdata_i[IdW-1:0];
        RegBroadcastId: cfg_d.broadcast_id = cfg_wdata_i[IdW-1:0];
        RegLedCount:    cfg_d.led_count    = cfg_wdata_i[CountW-1:0];
        RegShakeMs:     cfg_d.shake_ms     = cfg_wdata_i[DurW-1:0];
        RegIncendioMs:  cfg_d.incendio_ms  = cfg_wdata_i[DurW-1:0];
        RegAguamentiMs: cfg_d.aguamenti_ms = cfg_wdata_i[DurW-1:0];
        RegWaveMs:      cfg_d.wave_ms      = cfg_wdata_i[DurW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_id       <= 16'd1;
      cfg_q.broadcast_id <= 16'hFFFF;
      cfg_q.led_count    <= 4'd2;
      cfg_q.shake_ms     <= 16'd250;
      cfg_q.incendio_ms  <= 16'd3000;
      cfg_q.aguamenti_ms <= 16'd5000;
      cfg_q.wave_ms      <= 16'd3000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/bles_core.sv
// ----------------------------------------------------------------------------
// bles_core
// Effect state registers and the combinational update for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module bles_core (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  bles_pkg::cfg_t  cfg_i,
  input  wire logic    clr_ext_i,
  input  wire logic    fire_i,
  input  bles_pkg::item_t item_i,
  output bles_pkg::result_t res_o
);
  import bles_pkg::*;

  logic [TimeW-1:0]  now_q, now_d;
  logic [SeqW-1:0]   prev_seq_q, prev_seq_d;
  logic              seq_valid_q, seq_valid_d;
  logic              pulse_act_q, pulse_act_d;
  logic [TimeW-1:0]  pulse_end_q, pulse_end_d;
  logic              hold_q, hold_d;
  logic              wave_act_q, wave_act_d;
  logic [TimeW-1:0]  wave_end_q, wave_end_d;
  logic [TimeW-1:0]  wave_step_q, wave_step_d;
  logic [CountW-1:0] wave_lvl_q, wave_lvl_d;
  logic              beat_lit_q, beat_lit_d;
  logic [TimeW-1:0]  beat_next_q, beat_next_d;
  logic [TimeW-1:0]  beat_off_q, beat_off_d;
  result_t           led_q, led_d;

  logic [CountW-1:0]  used;
  logic [CountW-1:0]  wave_n;
  logic [MaxLeds:0]   used_mask_w;
  logic [MaxLeds-1:0] used_mask;
  logic               hit;
  logic [CountW-1:0]  lvl_inc;

  always_comb begin
    used        = (cfg_i.led_count > CountW'(MaxLeds)) ? CountW'(MaxLeds) : cfg_i.led_count;
    wave_n      = (used == '0) ? CountW'(1) : used;
    used_mask_w = ((MaxLeds+1)'(1) << used) - (MaxLeds+1)'(1);
    used_mask   = used_mask_w[MaxLeds-1:0];
    hit = ((item_i.dest_id == cfg_i.broadcast_id) || (item_i.dest_id == cfg_i.own_id))
          && !(seq_valid_q && (item_i.seq == prev_seq_q));
    lvl_inc = (wave_lvl_q + CountW'(1)) & LevelMask;
  end

  always_comb begin
    now_d       = now_q;
    prev_seq_d  = prev_seq_q;
    seq_valid_d = seq_valid_q;
    pulse_act_d = pulse_act_q;
    pulse_end_d = pulse_end_q;
    hold_d      = hold_q;
    wave_act_d  = wave_act_q;
    wave_end_d  = wave_end_q;
    wave_step_d = wave_step_q;
    wave_lvl_d  = wave_lvl_q;
    beat_lit_d  = beat_lit_q;
    beat_next_d = beat_next_q;
    beat_off_d  = beat_off_q;
    led_d       = led_q;
    led_d.accepted = 1'b0;

    if (clr_ext_i) begin
      led_d.ext = '0;
    end

    if (fire_i) begin
      if (!item_i.is_trig) begin
        now_d = now_q + TimeW'(1);
        if (wave_act_q) begin
          if (due(now_d, wave_end_q)) begin
            led_d.red   = 1'b0;
            led_d.green = 1'b0;
            led_d.blue  = 1'b0;
            led_d.ext   = led_q.ext & ~used_mask;
            wave_act_d  = 1'b0;
            beat_lit_d  = 1'b0;
            beat_next_d = now_d + BeatPeriod;
          end else if (due(now_d, wave_step_q)) begin
            wave_step_d = now_d + WaveStep;
            wave_lvl_d  = (lvl_inc > wave_n) ? '0 : lvl_inc;
            for (int i = 0; i < MaxLeds; i++) begin
              if (CountW'(i) < used) begin
                led_d.ext[i] = CountW'(i) < wave_lvl_d;
              end
            end
            led_d.blue  = wave_lvl_d != '0;
            led_d.green = wave_lvl_d >= wave_n;
          end
        end else if (!hold_q) begin
          if (pulse_act_q && due(now_d, pulse_end_q)) begin
            led_d.red   = 1'b0;
            led_d.ext   = led_q.ext & ~used_mask;
            pulse_act_d = 1'b0;
            pulse_end_d = '0;
          end
          if (!beat_lit_q) begin
            if (due(now_d, beat_next_q)) begin
              led_d.blue  = 1'b1;
              beat_lit_d  = 1'b1;
              beat_off_d  = now_d + BeatFlash;
              beat_next_d = now_d + BeatPeriod;
            end
          end else if (due(now_d, beat_off_q)) begin
            led_d.blue = 1'b0;
            beat_lit_d = 1'b0;
          end
        end
      end else if (hit) begin
        prev_seq_d     = item_i.seq;
        seq_valid_d    = 1'b1;
        led_d.accepted = 1'b1;
        case (item_i.trigger_code)
          TrigShake, TrigIncendio, TrigAguamenti: begin
            led_d.red   = 1'b1;
            led_d.ext   = led_q.ext | used_mask;
            pulse_act_d = 1'b1;
            wave_act_d  = 1'b0;
            case (item_i.trigger_code)
              TrigShake:    pulse_end_d = now_q + TimeW'(cfg_i.shake_ms);
              TrigIncendio: pulse_end_d = now_q + TimeW'(cfg_i.incendio_ms);
              default:      pulse_end_d = now_q + TimeW'(cfg_i.aguamenti_ms);
            endcase
          end
          TrigLumos: begin
            led_d.red   = 1'b1;
            led_d.green = 1'b1;
            led_d.blue  = 1'b1;
            led_d.ext   = led_q.ext | used_mask;
            hold_d      = 1'b1;
            pulse_act_d = 1'b0;
            pulse_end_d = '0;
            beat_lit_d  = 1'b1;
          end
          TrigNox: begin
            led_d.red   = 1'b0;
            led_d.green = 1'b0;
            led_d.blue  = 1'b0;
            led_d.ext   = led_q.ext & ~used_mask;
            hold_d      = 1'b0;
            wave_act_d  = 1'b0;
            pulse_act_d = 1'b0;
            pulse_end_d = '0;
            beat_lit_d  = 1'b0;
            beat_next_d = now_q + BeatPeriod;
          end
          TrigWave: begin
            wave_act_d  = 1'b1;
            wave_end_d  = now_q + TimeW'(cfg_i.wave_ms);
            wave_step_d = now_q;
            wave_lvl_d  = '0;
            hold_d      = 1'b0;
            pulse_act_d = 1'b0;
            pulse_end_d = '0;
            beat_lit_d  = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      prev_seq_q  <= SeqInit;
      seq_valid_q <= 1'b0;
      pulse_act_q <= 1'b0;
      pulse_end_q <= '0;
      hold_q      <= 1'b0;
      wave_act_q  <= 1'b0;
      wave_end_q  <= '0;
      wave_step_q <= '0;
      wave_lvl_q  <= '0;
      beat_lit_q  <= 1'b0;
      beat_next_q <= '0;
      beat_off_q  <= '0;
      led_q       <= '0;
    end else begin
      now_q       <= now_d;
      prev_seq_q  <= prev_seq_d;
      seq_valid_q <= seq_valid_d;
      pulse_act_q <= pulse_act_d;
      pulse_end_q <= pulse_end_d;
      hold_q      <= hold_d;
      wave_act_q  <= wave_act_d;
      wave_end_q  <= wave_end_d;
      wave_step_q <= wave_step_d;
      wave_lvl_q  <= wave_lvl_d;
      beat_lit_q  <= beat_lit_d;
      beat_next_q <= beat_next_d;
      beat_off_q  <= beat_off_d;
      led_q       <= led_d;
    end
  end

  assign res_o = led_d;

endmodule

`default_nettype wire

// File: sv/beacon_led_effect_sequencer.sv
// ----------------------------------------------------------------------------
// beacon_led_effect_sequencer
// LED effect sequencer driven by millisecond ticks and addressed triggers.
//
//   channel   dir  handshake            payload
//   s_axis    in   tvalid/tready        tdata item fields, tuser opcode
//   m_axis    out  tvalid/tready        tdata LED levels and accepted flag
//   cfg       in   cfg_we_i             cfg_addr_i, cfg_wdata_i
//
// One item per cycle sustained while results are taken. An item is held in the
// input register, which feeds the state update that loads the result register.
// While a result waits, the input register still takes one item; after that
// the input side stalls until the result is taken.
// Reset clears all effect state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module beacon_led_effect_sequencer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // seq[7:0], trigger_code[10:8], dest_id[26:11], zero pad[31:27]
  input  wire logic [bles_pkg::InDataW-1:0]  s_axis_tdata,
  // opcode
  input  wire logic                          s_axis_tuser,
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // red_on[0], green_on[1], blue_on[2], ext_on_mask[14:3], accepted[15]
  output      logic [bles_pkg::OutDataW-1:0] m_axis_tdata,
  input  wire logic                          cfg_we_i,
  input  wire logic [bles_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [bles_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import bles_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_vld_q;
  result_t res;
  result_t out_q;
  logic    out_vld_q;
  logic    fire;
  logic    clr_ext;

  assign fire          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;
  assign clr_ext       = cfg_we_i && (cfg_addr_i == RegLedCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.is_trig      <= s_axis_tuser;
      in_q.seq          <= s_axis_tdata[SeqW-1:0];
      in_q.trigger_code <= s_axis_tdata[SeqW+CodeW-1:SeqW];
      in_q.dest_id      <= s_axis_tdata[SeqW+CodeW+IdW-1:SeqW+CodeW];
    end
    if (fire) begin
      out_q <= res;
    end
  end

  bles_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bles_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .clr_ext_i (clr_ext),
    .fire_i    (fire),
    .item_i    (in_q),
    .res_o     (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire
